/* rtl/core/spi_clock_divider_search_macros.svh */
// Assertion macros for the serial clock divider search RTL
`ifndef SPI_CLOCK_DIVIDER_SEARCH_MACROS_SVH
`define SPI_CLOCK_DIVIDER_SEARCH_MACROS_SVH

// same-cycle implication, checked outside reset
`define SCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/scd_pkg.sv */
// Types, constants and microcode table of the serial clock divider search
package scd_pkg;

    localparam int NUM_W  = 32;
    localparam int DEN_W  = 40;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int MUL_W  = 17;
    localparam int LIM_W  = DEN_W + 9;
    localparam int STEP_W = 5;

    localparam logic [NUM_W-1:0] SYSCLK_RESET   = 32'd125000000;
    localparam logic [4:0]       FRAME_BITS_MIN = 5'd4;
    localparam logic [4:0]       FRAME_BITS_MAX = 5'd16;
    localparam logic [3:0]       SIZE_MASK      = 4'hF;
    localparam int               POL_BIT        = 6;
    localparam int               PHA_BIT        = 7;
    localparam logic [7:0]       SLAVE_PRESCALE = 8'd2;
    localparam logic [7:0]       FIRST_PRESCALE = 8'd2;
    localparam logic [7:0]       PRESCALE_STEP  = 8'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
    localparam logic [1:0] STATUS_BAD_RATE = 2'd2;

    typedef struct packed {
        logic [31:0] target_hz;
        logic [4:0]  frame_bits;
        logic        clock_polarity;
        logic        clock_phase;
        logic        slave_mode;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] control_word;
        logic [7:0]  prescale;
        logic [7:0]  serial_rate;
        logic        slave_enable;
        logic [31:0] actual_hz;
    } t_res;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_ADVANCE,
        OP_DIV_Q,
        OP_DIV_A,
        OP_DIV_STEP,
        OP_MUL,
        OP_KIND_OK,
        OP_KIND_ESIZE,
        OP_KIND_SLAVE,
        OP_KIND_ERATE,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_IN,
        C_BAD_SIZE,
        C_SLAVE,
        C_BAD_RATE,
        C_FIT,
        C_LAST_P,
        C_DIV_MORE,
        C_QZERO,
        C_OUT_BUSY
    } t_cond;

    typedef enum logic [1:0] {
        K_OK,
        K_SLAVE,
        K_ESIZE,
        K_ERATE
    } t_kind;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic bad_size;
        logic slave;
        logic bad_rate;
        logic fit;
        logic last_p;
        logic div_more;
        logic qzero;
    } t_dp_flags;

    typedef struct packed {
        logic      in_valid;
        logic      out_busy;
        t_dp_flags dp;
    } t_flags;

    localparam logic [STEP_W-1:0] A_IDLE      = 5'd0;
    localparam logic [STEP_W-1:0] A_CHK_SIZE  = 5'd1;
    localparam logic [STEP_W-1:0] A_CHK_SLAVE = 5'd2;
    localparam logic [STEP_W-1:0] A_CHK_RATE  = 5'd3;
    localparam logic [STEP_W-1:0] A_TRY       = 5'd4;
    localparam logic [STEP_W-1:0] A_TRY_LAST  = 5'd5;
    localparam logic [STEP_W-1:0] A_TRY_NEXT  = 5'd6;
    localparam logic [STEP_W-1:0] A_QDIV      = 5'd7;
    localparam logic [STEP_W-1:0] A_QDIV_RUN  = 5'd8;
    localparam logic [STEP_W-1:0] A_MUL       = 5'd9;
    localparam logic [STEP_W-1:0] A_ADIV      = 5'd10;
    localparam logic [STEP_W-1:0] A_ADIV_RUN  = 5'd11;
    localparam logic [STEP_W-1:0] A_ZERO      = 5'd12;
    localparam logic [STEP_W-1:0] A_OK        = 5'd13;
    localparam logic [STEP_W-1:0] A_ESIZE     = 5'd14;
    localparam logic [STEP_W-1:0] A_SLAVE     = 5'd15;
    localparam logic [STEP_W-1:0] A_ERATE     = 5'd16;
    localparam logic [STEP_W-1:0] A_EMIT      = 5'd17;
    localparam logic [STEP_W-1:0] A_DONE      = 5'd18;

    function automatic t_ctrl scd_rom(input logic [STEP_W-1:0] step);
        t_ctrl w;
        unique case (step)
            A_IDLE:      w = '{OP_LOAD,       C_NOT_IN,   A_IDLE};
            A_CHK_SIZE:  w = '{OP_NOP,        C_BAD_SIZE, A_ESIZE};
            A_CHK_SLAVE: w = '{OP_NOP,        C_SLAVE,    A_SLAVE};
            A_CHK_RATE:  w = '{OP_NOP,        C_BAD_RATE, A_ERATE};
            A_TRY:       w = '{OP_NOP,        C_FIT,      A_QDIV};
            A_TRY_LAST:  w = '{OP_NOP,        C_LAST_P,   A_ERATE};
            A_TRY_NEXT:  w = '{OP_ADVANCE,    C_ALWAYS,   A_TRY};
            A_QDIV:      w = '{OP_DIV_Q,      C_NEVER,    A_IDLE};
            A_QDIV_RUN:  w = '{OP_DIV_STEP,   C_DIV_MORE, A_QDIV_RUN};
            A_MUL:       w = '{OP_MUL,        C_NEVER,    A_IDLE};
            A_ADIV:      w = '{OP_DIV_A,      C_NEVER,    A_IDLE};
            A_ADIV_RUN:  w = '{OP_DIV_STEP,   C_DIV_MORE, A_ADIV_RUN};
            A_ZERO:      w = '{OP_NOP,        C_QZERO,    A_ERATE};
            A_OK:        w = '{OP_KIND_OK,    C_ALWAYS,   A_EMIT};
            A_ESIZE:     w = '{OP_KIND_ESIZE, C_ALWAYS,   A_EMIT};
            A_SLAVE:     w = '{OP_KIND_SLAVE, C_ALWAYS,   A_EMIT};
            A_ERATE:     w = '{OP_KIND_ERATE, C_ALWAYS,   A_EMIT};
            A_EMIT:      w = '{OP_EMIT,       C_OUT_BUSY, A_EMIT};
            A_DONE:      w = '{OP_NOP,        C_ALWAYS,   A_IDLE};
            default:     w = '{OP_NOP,        C_ALWAYS,   A_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/scd_divider.sv */
// Shift-subtract divider, one quotient bit per step
module scd_divider (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic                     i_step,
    input  logic [scd_pkg::NUM_W-1:0] i_num,
    input  logic [scd_pkg::DEN_W-1:0] i_den,
    output logic [scd_pkg::NUM_W-1:0] o_quo,
    output logic                     o_more
);
    import scd_pkg::*;

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             qbit;

    assign shifted = {r_rem, r_quo[NUM_W-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign qbit    = !diff[DEN_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (i_step) begin
            r_quo <= {r_quo[NUM_W-2:0], qbit};
            r_rem <= qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_more = (r_cnt != CNT_W'(NUM_W - 1));

endmodule

/* rtl/core/scd_datapath.sv */
// Datapath of the divider search: request, prescale, products, divider, result
module scd_datapath #(
    parameter int PRESCALE_MAX     = 254,
    parameter int RATE_DIVISOR_MAX = 255
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  scd_pkg::t_op             i_op,
    input  logic                     i_in_valid,
    input  scd_pkg::t_req            i_req,
    input  logic [scd_pkg::NUM_W-1:0] i_sysclk,
    output scd_pkg::t_dp_flags       o_flags,
    output scd_pkg::t_res            o_res
);
    import scd_pkg::*;

    localparam int RDIV_N = RATE_DIVISOR_MAX + 1;

    t_req             r_req;
    logic [7:0]       r_p;
    logic [DEN_W-1:0] r_d;
    logic [7:0]       r_rate;
    logic [MUL_W-1:0] r_m;
    t_kind            r_kind;

    logic [DEN_W-1:0] d_inc;
    logic [LIM_W-1:0] lim;
    logic [NUM_W-1:0] sys_m1;
    logic [8:0]       p_next;
    logic [8:0]       div_val;
    logic [NUM_W-1:0] quo;
    logic             more;
    logic             div_load;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [7:0]       base;

    assign d_inc   = {7'b0, r_req.target_hz, 1'b0};
    assign lim     = LIM_W'(r_d) * LIM_W'(RDIV_N);
    assign sys_m1  = i_sysclk - NUM_W'(1);
    assign p_next  = {1'b0, r_p} + {1'b0, PRESCALE_STEP};
    assign div_val = {1'b0, quo[7:0]} + 9'd1;

    assign div_load = (i_op == OP_DIV_Q) || (i_op == OP_DIV_A);
    assign div_num  = (i_op == OP_DIV_Q) ? sys_m1 : i_sysclk;
    assign div_den  = (i_op == OP_DIV_Q) ? r_d : DEN_W'(r_m);

    scd_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (div_load),
        .i_step (i_op == OP_DIV_STEP),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_quo  (quo),
        .o_more (more)
    );

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                if (i_in_valid) begin
                    r_req <= i_req;
                    r_p   <= FIRST_PRESCALE;
                    r_d   <= {7'b0, i_req.target_hz, 1'b0};
                end
            end
            OP_ADVANCE: begin
                r_p <= p_next[7:0];
                r_d <= r_d + d_inc;
            end
            OP_MUL: begin
                r_rate <= quo[7:0];
                r_m    <= MUL_W'(r_p) * MUL_W'(div_val);
            end
            OP_KIND_OK:    r_kind <= K_OK;
            OP_KIND_ESIZE: r_kind <= K_ESIZE;
            OP_KIND_SLAVE: r_kind <= K_SLAVE;
            OP_KIND_ERATE: r_kind <= K_ERATE;
            default: ;
        endcase
    end

    always_comb begin
        o_flags.bad_size = (r_req.frame_bits < FRAME_BITS_MIN) ||
                           (r_req.frame_bits > FRAME_BITS_MAX);
        o_flags.slave    = r_req.slave_mode;
        o_flags.bad_rate = (r_req.target_hz == '0) || (r_req.target_hz > i_sysclk);
        o_flags.fit      = {(LIM_W - NUM_W)'(0), sys_m1} < lim;
        o_flags.last_p   = p_next > 9'(PRESCALE_MAX);
        o_flags.div_more = more;
        o_flags.qzero    = (quo == '0);
    end

    always_comb begin
        base                = '0;
        base[3:0]           = (r_req.frame_bits[3:0] - 4'd1) & SIZE_MASK;
        base[POL_BIT]       = r_req.clock_polarity;
        base[PHA_BIT]       = r_req.clock_phase;
        o_res               = '0;
        unique case (r_kind)
            K_OK: begin
                o_res.status       = STATUS_OK;
                o_res.control_word = {r_rate, base};
                o_res.prescale     = r_p;
                o_res.serial_rate  = r_rate;
                o_res.actual_hz    = quo;
            end
            K_SLAVE: begin
                o_res.status       = STATUS_OK;
                o_res.control_word = {8'b0, base};
                o_res.prescale     = SLAVE_PRESCALE;
                o_res.slave_enable = 1'b1;
            end
            K_ESIZE: o_res.status = STATUS_BAD_SIZE;
            K_ERATE: o_res.status = STATUS_BAD_RATE;
            default: o_res.status = STATUS_BAD_RATE;
        endcase
    end

endmodule

/* rtl/core/scd_sequencer.sv */
// Microcode sequencer: step counter, control table and conditional jumps
`include "spi_clock_divider_search_macros.svh"

module scd_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  scd_pkg::t_flags i_flags,
    output scd_pkg::t_ctrl  o_ctrl,
    output logic           o_idle
);
    import scd_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             ctrl;
    logic              take;

    assign ctrl = scd_rom(r_step);

    always_comb begin
        unique case (ctrl.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NOT_IN:   take = !i_flags.in_valid;
            C_BAD_SIZE: take = i_flags.dp.bad_size;
            C_SLAVE:    take = i_flags.dp.slave;
            C_BAD_RATE: take = i_flags.dp.bad_rate;
            C_FIT:      take = i_flags.dp.fit;
            C_LAST_P:   take = i_flags.dp.last_p;
            C_DIV_MORE: take = i_flags.dp.div_more;
            C_QZERO:    take = i_flags.dp.qzero;
            C_OUT_BUSY: take = i_flags.out_busy;
            default:    take = 1'b1;
        endcase
        n_step = take ? ctrl.target : r_step + STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= A_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = ctrl;
    assign o_idle = (r_step == A_IDLE);

    `SCD_ASSERT_NEXT(a_emit_hold, i_clk, i_rst_n, (r_step == A_EMIT) && i_flags.out_busy, r_step == A_EMIT, "result dropped while output busy")
    `SCD_ASSERT_NEXT(a_idle_hold, i_clk, i_rst_n, (r_step == A_IDLE) && !i_flags.in_valid, r_step == A_IDLE, "left idle without a request")
    `SCD_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, r_step == A_TRY_NEXT, !i_flags.dp.last_p, "prescale advanced past its limit")
    `SCD_ASSERT_NOW(a_step_range, i_clk, i_rst_n, 1'b1, r_step <= A_DONE, "step outside the program")

endmodule

/* rtl/core/spi_clock_divider_search.sv */
// Top level of the serial port clock divider search
//
// Request channel: i_in_valid / o_in_stall carry one t_req beat (target rate,
// frame size, polarity, phase, slave flag). A beat is taken when valid is high
// and stall low. Result channel: o_out_valid / i_out_stall carry one t_res beat
// per request. Configuration: i_cfg_valid / o_cfg_ready write the system clock
// frequency; o_cfg_ready is always high. Write it only while no request is open.
// A request is handled by a microcode program, one step per cycle. It checks
// the frame size, then slave mode, then whether the rate is out of range. A
// master tries the even prescales in rising order (up to 127 tries), then
// runs two 32-step divisions. The worst case from request to result is set by
// the shared shift-subtract divider and the serial prescale loop.
// One request is in work at a time; the next is taken when the sequencer has
// passed through A_DONE back to A_IDLE after the result has been moved to the
// output register, even while the receiver stalls it.
// A stalled result holds in the output register until taken.
// Reset: the system clock register returns to 125 MHz, the sequencer goes idle
// and the output register empties.
module spi_clock_divider_search #(
    parameter int PRESCALE_MAX     = 254,
    parameter int RATE_DIVISOR_MAX = 255
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  scd_pkg::t_req             i_in_req,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output scd_pkg::t_res             o_out_res,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [scd_pkg::NUM_W-1:0] i_cfg_data
);
    import scd_pkg::*;

    logic [NUM_W-1:0] r_sysclk;
    logic             r_out_valid;
    t_res             r_out_res;
    t_ctrl            ctrl;
    t_dp_flags        dp_flags;
    t_flags           flags;
    t_res             res;
    logic             idle;
    logic             out_busy;
    logic             emit;

    assign o_cfg_ready = 1'b1;
    assign out_busy    = r_out_valid && i_out_stall;
    assign emit        = (ctrl.op == OP_EMIT) && !out_busy;
    assign o_in_stall  = !idle;

    always_comb begin
        flags.in_valid = i_in_valid;
        flags.out_busy = out_busy;
        flags.dp       = dp_flags;
    end

    scd_sequencer u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_flags(flags),
        .o_ctrl (ctrl),
        .o_idle (idle)
    );

    scd_datapath #(
        .PRESCALE_MAX    (PRESCALE_MAX),
        .RATE_DIVISOR_MAX(RATE_DIVISOR_MAX)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (ctrl.op),
        .i_in_valid(i_in_valid),
        .i_req     (i_in_req),
        .i_sysclk  (r_sysclk),
        .o_flags   (dp_flags),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sysclk <= SYSCLK_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sysclk <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_res <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule

/* verif/spi_clock_divider_search_test.sv */
// Self-checking testbench for the serial clock divider search block
`timescale 1ns / 1ps

module spi_clock_divider_search_test;
    import scd_pkg::*;

    localparam int PRESCALE_LIMIT   = 254;
    localparam int RATE_LIMIT       = 255;
    localparam int MAX_GAP          = 19;
    localparam int HOLD_CYCLES      = 3000;
    localparam int SETTLE_CYCLES    = 16;
    localparam int DRAIN_CYCLES     = 500;
    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int NUM_PHASES       = 6;
    localparam int RANDOM_PER_PHASE = 12;
    localparam int REPORT_LIMIT     = 10;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    t_req             i_in_req    = '0;
    logic             i_out_stall = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic [NUM_W-1:0] i_cfg_data  = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_res             o_out_res;
    logic             o_cfg_ready;

    bit no_idle      = 1'b0;
    bit hold_off_req = 1'b0;

    class setup_scoreboard;
        t_res             awaited[$];
        logic [NUM_W-1:0] sysclk_hz;
        int               mismatches;

        function new();
            sysclk_hz  = SYSCLK_RESET;
            mismatches = 0;
        endfunction

        function void set_sysclk(logic [NUM_W-1:0] hz);
            sysclk_hz = hz;
        endfunction

        function t_res expected_setup(t_req r);
            t_res        res;
            logic [15:0] base;
            logic [63:0] clk64, p, prod, div, actual;
            logic        found;
            res    = '0;
            base   = '0;
            clk64  = {32'd0, sysclk_hz};
            actual = '0;
            found  = 1'b0;
            if (r.frame_bits < FRAME_BITS_MIN || r.frame_bits > FRAME_BITS_MAX) begin
                res.status = STATUS_BAD_SIZE;
            end else begin
                base[3:0]     = 4'(r.frame_bits - 5'd1) & SIZE_MASK;
                base[POL_BIT] = r.clock_polarity;
                base[PHA_BIT] = r.clock_phase;
                if (r.slave_mode) begin
                    res.control_word = base;
                    res.prescale     = SLAVE_PRESCALE;
                    res.slave_enable = 1'b1;
                end else if (r.target_hz == 0 || r.target_hz > sysclk_hz) begin
                    res.status = STATUS_BAD_RATE;
                end else begin
                    for (p = 2; p <= PRESCALE_LIMIT && !found; p = p + 2) begin
                        prod = p * r.target_hz;
                        div  = (clk64 + prod - 1) / prod;
                        if (div == 0) begin
                            div = 1;
                        end
                        if (div - 1 <= RATE_LIMIT) begin
                            found           = 1'b1;
                            actual          = clk64 / (p * div);
                            res.prescale    = p[7:0];
                            res.serial_rate = 8'(div - 1);
                        end
                    end
                    if (!found || actual == 0) begin
                        res = '0;
                        res.status = STATUS_BAD_RATE;
                    end else begin
                        res.control_word = base | {res.serial_rate, 8'h00};
                        res.actual_hz    = actual[31:0];
                    end
                end
            end
            return res;
        endfunction

        function void note_request(t_req r);
            awaited.push_back(expected_setup(r));
        endfunction

        function void report(string what, logic [31:0] want_v, logic [31:0] got_v);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("mismatch %s: expected %0d, got %0d", what, want_v, got_v);
            end
        endfunction

        function void check_setup(t_res got);
            t_res want;
            if (awaited.size() == 0) begin
                report("pending results", 32'd0, 32'd1);
            end else begin
                want = awaited.pop_front();
                if (got.status !== want.status)
                    report("status", 32'(want.status), 32'(got.status));
                if (got.control_word !== want.control_word)
                    report("control_word", 32'(want.control_word), 32'(got.control_word));
                if (got.prescale !== want.prescale)
                    report("prescale", 32'(want.prescale), 32'(got.prescale));
                if (got.serial_rate !== want.serial_rate)
                    report("serial_rate", 32'(want.serial_rate), 32'(got.serial_rate));
                if (got.slave_enable !== want.slave_enable)
                    report("slave_enable", 32'(want.slave_enable), 32'(got.slave_enable));
                if (got.actual_hz !== want.actual_hz)
                    report("actual_hz", want.actual_hz, got.actual_hz);
            end
        endfunction
    endclass

    setup_scoreboard sb = new();

    spi_clock_divider_search #(
        .PRESCALE_MAX    (PRESCALE_LIMIT),
        .RATE_DIVISOR_MAX(RATE_LIMIT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_res  (o_out_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic t_req make_req(logic [31:0] target, logic [4:0] bits,
                                      logic pol, logic pha, logic slave);
        t_req r;
        r.target_hz      = target;
        r.frame_bits     = bits;
        r.clock_polarity = pol;
        r.clock_phase    = pha;
        r.slave_mode     = slave;
        return r;
    endfunction

    function automatic t_req random_req(logic [31:0] hz);
        int          pick;
        int          sh;
        logic [31:0] t;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            sh = $urandom_range(0, 17);
            t  = hz >> sh;
            if (t == 0) begin
                t = 1;
            end
            t = $urandom_range(t, t - t / 2);
            return make_req(t, 5'($urandom_range(4, 16)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'b0);
        end else if (pick < 85) begin
            return make_req($urandom, 5'($urandom_range(4, 16)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'b1);
        end
        return make_req($urandom, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    task automatic send_req(t_req r);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic write_sysclk(logic [NUM_W-1:0] hz);
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= hz;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_sysclk(hz);
    endtask

    // drain results
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = draw_gap();
            end
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            sb.check_setup(o_out_res);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL spi_clock_divider_search");
        $finish;
    end

    initial begin
        logic [NUM_W-1:0] clocks[NUM_PHASES];
        logic [NUM_W-1:0] hz;
        clocks = '{32'd125000000, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd48000000, 32'd0};
        clocks[NUM_PHASES-1] = $urandom;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            hz = clocks[ph];
            write_sysclk(hz);
            if (ph == 0) begin
                send_req(make_req(32'd1000000, 5'd0, 1'b0, 1'b0, 1'b0));
                send_req(make_req(32'd1000000, 5'd17, 1'b1, 1'b1, 1'b0));
                send_req(make_req(32'd1000000, 5'd31, 1'b0, 1'b0, 1'b1));
                send_req(make_req(32'd1000000, 5'd4, 1'b0, 1'b1, 1'b0));
                send_req(make_req(32'd1000000, 5'd16, 1'b1, 1'b0, 1'b0));
                send_req(make_req(32'd0, 5'd8, 1'b1, 1'b1, 1'b1));
                send_req(make_req(32'd0, 5'd8, 1'b0, 1'b0, 1'b0));
                send_req(make_req(hz + 1, 5'd8, 1'b0, 1'b0, 1'b0));
                send_req(make_req(32'd1923, 5'd8, 1'b0, 1'b0, 1'b0));
                send_req(make_req(32'd1922, 5'd8, 1'b0, 1'b0, 1'b0));
            end
            send_req(make_req(hz, 5'd8, 1'b1, 1'b0, 1'b0));
            send_req(make_req(32'd1, 5'd12, 1'b0, 1'b1, 1'b0));
            send_req(make_req(32'hFFFF_FFFF, 5'd5, 1'b1, 1'b1, 1'b0));
            if (ph == 0) begin
                hold_off_req = 1'b1;
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                no_idle = (i >= 6 && i < 11);
                send_req(random_req(hz));
            end
            no_idle = 1'b0;
            i_in_valid <= 1'b0;
        end
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("PASS spi_clock_divider_search");
        end else begin
            $display("FAIL spi_clock_divider_search");
        end
        $finish;
    end

endmodule
